### rtl/core/u8v_pkg.sv
// Package for the UTF-8 string validator: widths, bit-count limits and lead-byte decode.
// Used by utf8_string_validator and its checker; depends on nothing else.
package u8v_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 3;
    localparam int ACC_W     = 31;
    localparam int SHIFT_W   = 5;
    localparam int OUT_TDATA_W = 8;

    // Code returned by lead_length for the forbidden 0xFE and 0xFF lead bytes.
    localparam logic [LEN_W:0] LEAD_BAD = 4'd7;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [SHIFT_W-1:0] t_shift;

    // Number of leading ones of a lead byte that has its top two bits set.
    function automatic logic [LEN_W:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W:0] n;
        begin
            priority casez (b)
                8'b110?_????: n = 4'd2;
                8'b1110_????: n = 4'd3;
                8'b1111_0???: n = 4'd4;
                8'b1111_10??: n = 4'd5;
                8'b1111_110?: n = 4'd6;
                default:      n = LEAD_BAD;
            endcase
            return n;
        end
    endfunction

    // Smallest legal significant-bit count minus one, per sequence length.
    function automatic t_shift min_shift(input t_len len);
        t_shift s;
        begin
            unique case (len)
                3'd2:    s = 5'd7;
                3'd3:    s = 5'd11;
                3'd4:    s = 5'd16;
                3'd5:    s = 5'd21;
                3'd6:    s = 5'd26;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Largest legal significant-bit count per sequence length.
    function automatic t_shift max_shift(input t_len len);
        t_shift s;
        begin
            unique case (len)
                3'd2:    s = 5'd11;
                3'd3:    s = 5'd16;
                3'd4:    s = 5'd21;
                3'd5:    s = 5'd26;
                3'd6:    s = 5'd31;
                default: s = 5'd31;
            endcase
            return s;
        end
    endfunction

endpackage

### rtl/core/utf8_string_validator.sv
// Top level of the UTF-8 string validator: byte stream in, one verdict item per string out.
// Depends on u8v_pkg.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tdata[7:0] = byte_value (zero ends the string)
//  m_axis    | out       | tdata[0] = well_formed, tdata[7:1] = 0
//  cfg       | in        | i_cfg_wdata = allow_two_byte_nul
//
// One byte per cycle while no stalled verdict holds a zero byte: a byte waits in
// the input register, then the decode and the leading-one limit check update the
// string state in one step. A verdict is offered on m_axis once its zero byte has
// left the input register; the verdict register then holds it until m_axis takes it.
// Reset (synchronous, active low) clears the string state and the config bit.
// A stalled verdict holds the next zero byte in the input register, and with it
// every byte behind that zero; bytes ahead of it keep flowing.
module utf8_string_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // [7:0] byte_value
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata     // [0] well_formed, [7:1] zero
);

    logic                          r_allow;
    logic                          r_in_valid;
    logic [u8v_pkg::BYTE_W-1:0]    r_in_byte;
    u8v_pkg::t_len                 r_len, n_len;
    u8v_pkg::t_len                 r_seen, n_seen;
    logic [u8v_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic                          r_err, n_err;
    logic                          r_out_valid;
    logic                          r_out_wf;

    logic                          out_free;
    logic                          advance;
    logic                          in_zero;
    logic [u8v_pkg::LEN_W:0]       lead_n;
    logic [u8v_pkg::BYTE_W-1:0]    payload;
    logic [u8v_pkg::ACC_W-1:0]     acc_next;
    u8v_pkg::t_len                 seen_next;
    logic                          too_big;
    logic                          too_small;
    logic                          nul_ok;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_zero         = (r_in_byte == '0);
    assign advance         = r_in_valid && (!in_zero || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(u8v_pkg::OUT_TDATA_W-1){1'b0}}, r_out_wf};

    assign lead_n    = u8v_pkg::lead_length(r_in_byte);
    assign payload   = r_in_byte & (8'hFF >> (lead_n + 4'd1));
    assign acc_next  = {r_acc[u8v_pkg::ACC_W-7:0], r_in_byte[5:0]};
    assign seen_next = r_seen + 3'd1;

    // Bit-count limits as threshold tests on the completed code point.
    assign too_big   = (acc_next >> u8v_pkg::max_shift(r_len)) != '0;
    assign too_small = (acc_next >> u8v_pkg::min_shift(r_len)) == '0;
    assign nul_ok    = r_allow && (r_len == 3'd2) && (acc_next == '0);

    always_comb begin
        n_len  = r_len;
        n_seen = r_seen;
        n_acc  = r_acc;
        n_err  = r_err;
        if (in_zero) begin
            n_len  = '0;
            n_seen = '0;
            n_acc  = '0;
            n_err  = 1'b0;
        end else if (r_err) begin
            n_err = 1'b1;
        end else if (r_len == '0) begin
            if (r_in_byte[7]) begin
                if (!r_in_byte[6] || lead_n == u8v_pkg::LEAD_BAD) begin
                    n_err = 1'b1;
                end else begin
                    n_len  = lead_n[u8v_pkg::LEN_W-1:0];
                    n_seen = 3'd1;
                    n_acc  = {{(u8v_pkg::ACC_W-u8v_pkg::BYTE_W){1'b0}}, payload};
                end
            end
        end else if (r_in_byte[7:6] != 2'b10) begin
            n_err  = 1'b1;
            n_len  = '0;
            n_seen = '0;
            n_acc  = '0;
        end else if (seen_next < r_len) begin
            n_seen = seen_next;
            n_acc  = acc_next;
        end else begin
            // Sequence complete: accept it only inside its bit-count range, or as an allowed two-byte NUL.
            n_err  = !nul_ok && (too_big || too_small);
            n_len  = '0;
            n_seen = '0;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_len       <= '0;
            r_seen      <= '0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_allow <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_len  <= n_len;
                r_seen <= n_seen;
                r_acc  <= n_acc;
                r_err  <= n_err;
            end
            if (advance && in_zero) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance && in_zero) begin
            r_out_wf <= !r_err && (r_len == '0);
        end
    end

endmodule

### rtl/core/u8v_checker.sv
// Port-level checker for utf8_string_validator, bound to every instance of it.
// Depends on u8v_pkg.
module u8v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A verdict that is not taken stays offered with the same value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("verdict dropped or changed while stalled");

    // The input side only stalls behind a verdict that is itself stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled verdict");

    // Padding bits of the verdict item are always zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[u8v_pkg::OUT_TDATA_W-1:1] == '0)
        else $error("verdict padding not zero");

    // Reset leaves no verdict pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("verdict valid after reset");

    // A verdict appears only after the input side was ready, as it is when a zero byte is taken.
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(o_s_axis_tready))
        else $error("verdict appeared while input was stalled");

endmodule

bind utf8_string_validator u8v_checker u_u8v_checker (.*);
